/* rtl/ldpt_pkg.sv */
// Shared constants, widths and types of the laser pulses-per-inch trigger.
// No dependencies; every other file refers to this package by scoped names.
package ldpt_pkg;

	localparam int FRACTION_BITS = 8;

	localparam int POS_W      = 32;
	localparam int DELTA_W    = 15;
	localparam int SUMSQ_W    = 2 * DELTA_W + 1;
	localparam int ROOT_W     = (SUMSQ_W + 1) / 2 + FRACTION_BITS;
	localparam int ROOT_STEPS = (ROOT_W + 1) / 2;
	localparam int ROOT_PAD_W = 2 * ROOT_STEPS;
	localparam int RAD_W      = 4 * ROOT_STEPS;
	localparam int REM_W      = ROOT_PAD_W + 2;
	localparam int ACC_W      = 32;
	localparam int SPACING_W  = 24;
	localparam int SQ_CNT_W   = $clog2(DELTA_W + 1);
	localparam int RT_CNT_W   = $clog2(ROOT_STEPS + 1);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 24;

	localparam logic [DELTA_W-1:0]   DELTA_LIMIT   = {DELTA_W{1'b1}};
	localparam logic [SPACING_W-1:0] SPACING_RESET = SPACING_W'(54187);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PPI_MODE_ENABLE = 1'b0,
		CFG_PULSE_SPACING   = 1'b1
	} ldpt_cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ROOT,
		ST_ACCUM,
		ST_DONE
	} ldpt_state_t;

endpackage

/* rtl/ldpt_if.sv */
// Valid/ready channel interfaces: position samples in, trigger results out,
// and register writes. Widths come from ldpt_pkg.
interface ldpt_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [ldpt_pkg::POS_W-1:0]   x_position;
	logic signed [ldpt_pkg::POS_W-1:0]   y_position;
	logic                                laser_enabled;
	logic                                pulse_active;

	modport source (output valid, x_position, y_position, laser_enabled, pulse_active,
		input ready);
	modport sink (input valid, x_position, y_position, laser_enabled, pulse_active,
		output ready);
endinterface

interface ldpt_out_if;
	logic valid;
	logic ready;
	logic fire_pulse;

	modport source (output valid, fire_pulse, input ready);
	modport sink (input valid, fire_pulse, output ready);
endinterface

interface ldpt_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [ldpt_pkg::CFG_IDX_W-1:0]      index;
	logic [ldpt_pkg::CFG_DATA_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/ldpt_sqmag.sv */
// Bit-serial sum of squares dx*dx + dy*dy, one multiplier bit per cycle,
// most significant bit first. Depends on ldpt_pkg.
module ldpt_sqmag (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ldpt_pkg::DELTA_W-1:0]   dx,
	input  logic [ldpt_pkg::DELTA_W-1:0]   dy,
	output logic                           done,
	output logic [ldpt_pkg::SUMSQ_W-1:0]   sum_sq
);

	logic                            busy_q;
	logic [ldpt_pkg::SQ_CNT_W-1:0]   cnt_q;
	logic [ldpt_pkg::DELTA_W-1:0]    mx_q, my_q;
	logic [ldpt_pkg::DELTA_W-1:0]    dxm_q, dym_q;
	logic [ldpt_pkg::SUMSQ_W-1:0]    acc_q;
	logic [ldpt_pkg::SUMSQ_W-1:0]    acc_next;
	logic [ldpt_pkg::SUMSQ_W-1:0]    add_x, add_y;

	always_comb begin
		add_x    = mx_q[ldpt_pkg::DELTA_W-1] ? ldpt_pkg::SUMSQ_W'(dxm_q) : '0;
		add_y    = my_q[ldpt_pkg::DELTA_W-1] ? ldpt_pkg::SUMSQ_W'(dym_q) : '0;
		acc_next = {acc_q[ldpt_pkg::SUMSQ_W-2:0], 1'b0} + add_x + add_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= ldpt_pkg::SQ_CNT_W'(ldpt_pkg::DELTA_W);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
			mx_q  <= dx;
			my_q  <= dy;
			dxm_q <= dx;
			dym_q <= dy;
		end else if (busy_q && cnt_q != '0) begin
			acc_q <= acc_next;
			mx_q  <= {mx_q[ldpt_pkg::DELTA_W-2:0], 1'b0};
			my_q  <= {my_q[ldpt_pkg::DELTA_W-2:0], 1'b0};
		end
	end

	assign done   = busy_q && (cnt_q == '0);
	assign sum_sq = acc_q;

endmodule

/* rtl/ldpt_isqrt.sv */
// Digit-by-digit integer square root of sum_sq << (2*FRACTION_BITS),
// two root bits per cycle. Depends on ldpt_pkg.
module ldpt_isqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ldpt_pkg::SUMSQ_W-1:0]   radicand,
	output logic                           done,
	output logic [ldpt_pkg::ROOT_W-1:0]    root
);

	localparam int PAD_HI = ldpt_pkg::RAD_W - ldpt_pkg::SUMSQ_W - 2 * ldpt_pkg::FRACTION_BITS;
	localparam int PAD_LO = 2 * ldpt_pkg::FRACTION_BITS;
	localparam int STEP_W = ldpt_pkg::REM_W + ldpt_pkg::ROOT_PAD_W;

	logic                              busy_q;
	logic [ldpt_pkg::RT_CNT_W-1:0]     cnt_q;
	logic [ldpt_pkg::RAD_W-1:0]        n_q;
	logic [ldpt_pkg::REM_W-1:0]        rem_q;
	logic [ldpt_pkg::ROOT_PAD_W-1:0]   root_q;
	logic [STEP_W-1:0]                 step_a, step_b;

	// one root digit: bring down a bit pair, try 4q+1
	function automatic logic [STEP_W-1:0] root_step(
		input logic [ldpt_pkg::REM_W-1:0]      r,
		input logic [ldpt_pkg::ROOT_PAD_W-1:0] q,
		input logic [1:0]                      pair
	);
		logic [ldpt_pkg::REM_W-1:0]      r_sh;
		logic [ldpt_pkg::REM_W-1:0]      trial;
		logic [ldpt_pkg::REM_W-1:0]      r_n;
		logic [ldpt_pkg::ROOT_PAD_W-1:0] q_n;
		r_sh  = {r[ldpt_pkg::REM_W-3:0], pair};
		trial = {q, 2'b01};
		if (r_sh >= trial) begin
			r_n = r_sh - trial;
			q_n = {q[ldpt_pkg::ROOT_PAD_W-2:0], 1'b1};
		end else begin
			r_n = r_sh;
			q_n = {q[ldpt_pkg::ROOT_PAD_W-2:0], 1'b0};
		end
		return {r_n, q_n};
	endfunction

	always_comb begin
		step_a = root_step(rem_q, root_q, n_q[ldpt_pkg::RAD_W-1 -: 2]);
		step_b = root_step(step_a[STEP_W-1 -: ldpt_pkg::REM_W],
			step_a[ldpt_pkg::ROOT_PAD_W-1:0], n_q[ldpt_pkg::RAD_W-3 -: 2]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= ldpt_pkg::RT_CNT_W'(ldpt_pkg::ROOT_STEPS);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= {{PAD_HI{1'b0}}, radicand, {PAD_LO{1'b0}}};
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q && cnt_q != '0) begin
			n_q    <= {n_q[ldpt_pkg::RAD_W-5:0], 4'b0000};
			rem_q  <= step_b[STEP_W-1 -: ldpt_pkg::REM_W];
			root_q <= step_b[ldpt_pkg::ROOT_PAD_W-1:0];
		end
	end

	assign done = busy_q && (cnt_q == '0);
	assign root = root_q[ldpt_pkg::ROOT_W-1:0];

endmodule

/* rtl/laser_distance_pulse_trigger.sv */
// Laser pulses-per-inch trigger: sequencer, position deltas, accumulator,
// registers and result register. Depends on ldpt_pkg, ldpt_if, ldpt_sqmag, ldpt_isqrt.
//
// Usage: in_ch carries one latched X/Y step-counter sample with the laser-enable
// level and the pulse-timer busy flag. Every transfer on in_ch yields exactly one
// transfer on out_ch whose fire_pulse asks the timer to start one pulse.
// cfg_ch writes ppi_mode_enable (index 0) and pulse_spacing (index 1); it is always
// ready, and writes are meant to land while no sample is in flight.
// Sequence: a sample that moves the head in PPI mode is taken, then passes through
// bit-serial squaring (15 bit steps and a finish step), square root (12 two-bit
// steps and a finish step), accumulate and compare, and the load of the result
// register once it is free; the sequencer then returns to idle and takes the next sample.
// A sample that causes no travel goes from idle straight to the result register load.
// Reset clears the stored position and the travel accumulator, selects PPI mode and
// a spacing of 54187 (1/30 inch per pulse in 8-bit fractional steps).
// The result register holds its value while out_ch is stalled; one new sample can
// still be taken meanwhile, and its result waits until the register is free.
module laser_distance_pulse_trigger (
	input  logic       clk,
	input  logic       arst_n,
	ldpt_in_if.sink    in_ch,
	ldpt_out_if.source out_ch,
	ldpt_cfg_if.sink   cfg_ch
);

	ldpt_pkg::ldpt_state_t state_q, state_next;

	logic                               mode_q;
	logic [ldpt_pkg::SPACING_W-1:0]     spacing_q;
	logic [ldpt_pkg::POS_W-1:0]         last_x_q, last_y_q;
	logic [ldpt_pkg::ACC_W-1:0]         trav_q;
	logic                               fire_pend_q;
	logic                               out_valid_q;
	logic                               out_fire_q;

	logic                               in_xfer;
	logic                               moved;
	logic                               qualify;
	logic [ldpt_pkg::DELTA_W-1:0]       dx, dy;
	logic                               sq_start, sq_done;
	logic [ldpt_pkg::SUMSQ_W-1:0]       sum_sq;
	logic                               rt_start, rt_done;
	logic [ldpt_pkg::ROOT_W-1:0]        root;
	logic [ldpt_pkg::ACC_W:0]           acc_sum;
	logic [ldpt_pkg::ACC_W-1:0]         acc_sat;
	logic                               acc_fire;
	logic                               out_free;
	logic                               out_load;
	logic                               accum_en;

	// |a - b| of two signed positions, saturated to the delta limit
	function automatic logic [ldpt_pkg::DELTA_W-1:0] clamp_delta(
		input logic [ldpt_pkg::POS_W-1:0] a,
		input logic [ldpt_pkg::POS_W-1:0] b
	);
		logic [ldpt_pkg::POS_W:0] d_ab;
		logic [ldpt_pkg::POS_W:0] d_ba;
		logic [ldpt_pkg::POS_W:0] mag;
		d_ab = {a[ldpt_pkg::POS_W-1], a} - {b[ldpt_pkg::POS_W-1], b};
		d_ba = {b[ldpt_pkg::POS_W-1], b} - {a[ldpt_pkg::POS_W-1], a};
		mag  = d_ab[ldpt_pkg::POS_W] ? d_ba : d_ab;
		if (|mag[ldpt_pkg::POS_W:ldpt_pkg::DELTA_W]) begin
			return ldpt_pkg::DELTA_LIMIT;
		end
		return mag[ldpt_pkg::DELTA_W-1:0];
	endfunction

	assign in_xfer  = in_ch.valid && in_ch.ready;
	assign moved    = (in_ch.x_position != last_x_q) || (in_ch.y_position != last_y_q);
	assign qualify  = mode_q && !in_ch.pulse_active && in_ch.laser_enabled && moved;
	assign dx       = clamp_delta(last_x_q, in_ch.x_position);
	assign dy       = clamp_delta(last_y_q, in_ch.y_position);
	assign out_free = !out_valid_q || out_ch.ready;

	ldpt_sqmag u_sqmag (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.dx     (dx),
		.dy     (dy),
		.done   (sq_done),
		.sum_sq (sum_sq)
	);

	ldpt_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rt_start),
		.radicand (sum_sq),
		.done     (rt_done),
		.root     (root)
	);

	always_comb begin
		acc_sum  = {1'b0, trav_q} + (ldpt_pkg::ACC_W + 1)'(root);
		acc_sat  = acc_sum[ldpt_pkg::ACC_W] ? '1 : acc_sum[ldpt_pkg::ACC_W-1:0];
		acc_fire = acc_sat >= ldpt_pkg::ACC_W'(spacing_q);
	end

	// next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ldpt_pkg::ST_IDLE: begin
				if (in_xfer) begin
					state_next = qualify ? ldpt_pkg::ST_SQUARE : ldpt_pkg::ST_DONE;
				end
			end
			ldpt_pkg::ST_SQUARE: begin
				if (sq_done) begin
					state_next = ldpt_pkg::ST_ROOT;
				end
			end
			ldpt_pkg::ST_ROOT: begin
				if (rt_done) begin
					state_next = ldpt_pkg::ST_ACCUM;
				end
			end
			ldpt_pkg::ST_ACCUM: state_next = ldpt_pkg::ST_DONE;
			ldpt_pkg::ST_DONE: begin
				if (out_free) begin
					state_next = ldpt_pkg::ST_IDLE;
				end
			end
			default: state_next = ldpt_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ch.ready = 1'b0;
		sq_start    = 1'b0;
		rt_start    = 1'b0;
		accum_en    = 1'b0;
		out_load    = 1'b0;
		unique case (state_q)
			ldpt_pkg::ST_IDLE: begin
				in_ch.ready = 1'b1;
				sq_start    = in_ch.valid && qualify;
			end
			ldpt_pkg::ST_SQUARE: rt_start = sq_done;
			ldpt_pkg::ST_ROOT:   ;
			ldpt_pkg::ST_ACCUM:  accum_en = 1'b1;
			ldpt_pkg::ST_DONE:   out_load = out_free;
			default:             ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ldpt_pkg::ST_IDLE;
			mode_q      <= 1'b1;
			spacing_q   <= ldpt_pkg::SPACING_RESET;
			last_x_q    <= '0;
			last_y_q    <= '0;
			trav_q      <= '0;
			fire_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_fire_q  <= 1'b0;
		end else begin
			state_q <= state_next;

			if (cfg_ch.valid) begin
				unique case (ldpt_pkg::ldpt_cfg_idx_t'(cfg_ch.index))
					ldpt_pkg::CFG_PPI_MODE_ENABLE: mode_q <= cfg_ch.data[0];
					ldpt_pkg::CFG_PULSE_SPACING:
						spacing_q <= cfg_ch.data[ldpt_pkg::SPACING_W-1:0];
				endcase
			end

			if (in_xfer) begin
				fire_pend_q <= 1'b0;
				if (qualify) begin
					last_x_q <= in_ch.x_position;
					last_y_q <= in_ch.y_position;
				end
			end

			if (accum_en) begin
				fire_pend_q <= acc_fire;
				trav_q      <= acc_fire ? '0 : acc_sat;
			end

			// hold the result until the transfer completes
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_fire_q  <= fire_pend_q;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign cfg_ch.ready      = 1'b1;
	assign out_ch.valid      = out_valid_q;
	assign out_ch.fire_pulse = out_fire_q;

	a_idle_skip: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && !qualify |=> state_q == ldpt_pkg::ST_DONE)
		else $error("sample without travel did not go straight to the result");

	a_root_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		rt_done |-> state_q == ldpt_pkg::ST_ROOT)
		else $error("square root finished outside its step");

	a_sq_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> state_q == ldpt_pkg::ST_SQUARE)
		else $error("squaring finished outside its step");

	a_fire_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accum_en && acc_fire |=> trav_q == '0 && fire_pend_q)
		else $error("pulse request did not clear the travel accumulator");

endmodule

/* sim/tb_top.sv */
// Self-checking bench for laser_distance_pulse_trigger: directed rows, then random walks.
// Depends on ldpt_pkg, ldpt_if and the RTL top; an internal trigger predictor checks results.
module tb_top;

	typedef struct packed {
		logic signed [ldpt_pkg::POS_W-1:0] x;
		logic signed [ldpt_pkg::POS_W-1:0] y;
		logic                              laser;
		logic                              busy;
	} sample_t;

	typedef struct packed {
		logic known;
		logic fire;
	} typed_fire_t;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	typedef struct packed {
		row_kind_t                            kind;
		sample_t                              s;
		logic                                 known;
		logic                                 fire;
		logic                                 ppi;
		logic [ldpt_pkg::SPACING_W-1:0]       spacing;
	} dir_row_t;

	localparam int  HOLD_CYCLES   = 300;
	localparam int  CYCLE_LIMIT   = 600000;
	localparam int  PHASE_ITEMS   = 160;
	localparam int  DRAIN_CYCLES  = 40;
	localparam longint unsigned TRAVEL_MAX = 64'hFFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n;

	ldpt_in_if  in_ch();
	ldpt_out_if out_ch();
	ldpt_cfg_if cfg_ch();

	laser_distance_pulse_trigger u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Predicted block state
	logic                           ppi_on     = 1'b1;
	logic [ldpt_pkg::SPACING_W-1:0] spacing_q  = ldpt_pkg::SPACING_RESET;
	logic signed [ldpt_pkg::POS_W-1:0] last_x  = '0;
	logic signed [ldpt_pkg::POS_W-1:0] last_y  = '0;
	logic [ldpt_pkg::ACC_W-1:0]     travelled  = '0;

	logic        fire_expect_q [$];
	typed_fire_t typed_q [$];
	dir_row_t    dir_table [$];

	int items_sent   = 0;
	int results_seen = 0;
	int err_count    = 0;
	int cycle_count  = 0;
	int hold_asked   = 0;
	int hold_done    = 0;
	logic calm       = 1'b0;
	int walk_x       = 0;
	int walk_y       = 0;
	int big_pct      = 10;

	function automatic longint unsigned int_sqrt64(input longint unsigned n);
		longint unsigned root_acc;
		longint unsigned probe;
		root_acc = 0;
		probe    = 64'd1 << 62;
		while (probe > n)
			probe >>= 2;
		while (probe != 0) begin
			if (n >= root_acc + probe) begin
				n        = n - (root_acc + probe);
				root_acc = (root_acc >> 1) + probe;
			end else begin
				root_acc >>= 1;
			end
			probe >>= 2;
		end
		return root_acc;
	endfunction

	function automatic longint unsigned axis_travel(input logic signed [31:0] a,
			input logic signed [31:0] b);
		longint d;
		d = longint'(a) - longint'(b);
		if (d < 0)
			d = -d;
		return (d > longint'(ldpt_pkg::DELTA_LIMIT)) ? longint'(ldpt_pkg::DELTA_LIMIT) : d;
	endfunction

	// Advance the trigger state by one sample and return the pulse request
	function automatic logic trigger_step(input sample_t s);
		longint unsigned dx;
		longint unsigned dy;
		longint unsigned sum;
		logic            fire;
		fire = 1'b0;
		if (ppi_on && !s.busy && s.laser && (s.x != last_x || s.y != last_y)) begin
			dx  = axis_travel(last_x, s.x);
			dy  = axis_travel(last_y, s.y);
			sum = longint'(travelled) +
				int_sqrt64((dx * dx + dy * dy) << (2 * ldpt_pkg::FRACTION_BITS));
			last_x = s.x;
			last_y = s.y;
			if (sum > TRAVEL_MAX)
				sum = TRAVEL_MAX;
			if (sum >= longint'(spacing_q)) begin
				fire      = 1'b1;
				travelled = '0;
			end else begin
				travelled = sum[31:0];
			end
		end
		return fire;
	endfunction

	function automatic dir_row_t mv(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic laser, input logic busy, input logic known, input logic fire);
		dir_row_t r;
		r         = '0;
		r.kind    = ROW_SAMPLE;
		r.s       = '{x, y, laser, busy};
		r.known   = known;
		r.fire    = fire;
		return r;
	endfunction

	function automatic dir_row_t wr(input logic ppi, input logic [23:0] spacing);
		dir_row_t r;
		r         = '0;
		r.kind    = ROW_WRITE;
		r.ppi     = ppi;
		r.spacing = spacing;
		return r;
	endfunction

	// Small walks or jumps (jump share set by big_pct), some repeats and fully random positions; laser mostly on
	function automatic sample_t next_sample();
		sample_t s;
		int      r;
		int      jump;
		r = $urandom_range(99);
		if (r < 5) begin
			walk_x = $urandom;
			walk_y = $urandom;
		end else if (r < 10) begin
		end else if (r < 10 + big_pct) begin
			jump = $urandom_range(70000, 20000);
			walk_x += $urandom_range(1) ? jump : -jump;
			jump = $urandom_range(70000, 0);
			walk_y += $urandom_range(1) ? jump : -jump;
		end else begin
			walk_x += int'($urandom_range(800)) - 400;
			walk_y += int'($urandom_range(800)) - 400;
		end
		s.x     = walk_x;
		s.y     = walk_y;
		s.laser = $urandom_range(99) < 88;
		s.busy  = $urandom_range(99) < 12;
		return s;
	endfunction

	task automatic note_fail(input string msg);
		err_count++;
		if (err_count <= 10)
			$display("%s", msg);
	endtask

	task automatic push_sample(input sample_t s, input logic known, input logic fire);
		typed_q.push_back('{known, fire});
		in_ch.valid         <= 1'b1;
		in_ch.x_position    <= s.x;
		in_ch.y_position    <= s.y;
		in_ch.laser_enabled <= s.laser;
		in_ch.pulse_active  <= s.busy;
		do @(posedge clk); while (!in_ch.ready);
		items_sent++;
	endtask

	task automatic maybe_pause();
		if (!calm && $urandom_range(99) < 20) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(36, 1)) @(posedge clk);
		end
	endtask

	// Stop offering and wait until every transferred sample has its result
	task automatic settle();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (results_seen != items_sent);
	endtask

	task automatic write_regs(input logic ppi, input logic [23:0] spacing);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= ldpt_pkg::CFG_PPI_MODE_ENABLE;
		cfg_ch.data  <= {23'b0, ppi};
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.index <= ldpt_pkg::CFG_PULSE_SPACING;
		cfg_ch.data  <= spacing;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n && cfg_ch.valid && cfg_ch.ready) begin
			case (cfg_ch.index)
				ldpt_pkg::CFG_PPI_MODE_ENABLE: ppi_on    = cfg_ch.data[0];
				ldpt_pkg::CFG_PULSE_SPACING:   spacing_q = cfg_ch.data;
				default: ;
			endcase
		end
	end

	always @(posedge clk) begin : take_sample
		sample_t     s;
		logic        pred;
		typed_fire_t typed;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			s     = '{in_ch.x_position, in_ch.y_position, in_ch.laser_enabled,
				in_ch.pulse_active};
			pred  = trigger_step(s);
			typed = typed_q.pop_front();
			fire_expect_q.push_back(typed.known ? typed.fire : pred);
		end
	end

	always @(posedge clk) begin : check_result
		logic want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (fire_expect_q.size() == 0) begin
				note_fail($sformatf("result %0d with nothing expected: fire_pulse=%b",
					results_seen, out_ch.fire_pulse));
			end else begin
				want = fire_expect_q.pop_front();
				if (out_ch.fire_pulse !== want)
					note_fail($sformatf("result %0d fire_pulse: expected %b, got %b",
						results_seen, want, out_ch.fire_pulse));
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off on request
	initial begin : result_ready
		int stall_cycles;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_asked != hold_done) begin
				out_ch.ready <= 1'b0;
				for (stall_cycles = 0; stall_cycles < HOLD_CYCLES; stall_cycles++)
					@(posedge clk);
				hold_done <= hold_done + 1;
			end else begin
				out_ch.ready <= calm || ($urandom_range(99) >= 20);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("laser_distance_pulse_trigger verification failed");
			$finish;
		end
	end

	initial begin : stimulus
		int ph;
		int n;
		logic mode;
		logic [23:0] spacing;
		arst_n              <= 1'b0;
		in_ch.valid         <= 1'b0;
		in_ch.x_position    <= '0;
		in_ch.y_position    <= '0;
		in_ch.laser_enabled <= 1'b0;
		in_ch.pulse_active  <= 1'b0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.index        <= ldpt_pkg::CFG_PPI_MODE_ENABLE;
		cfg_ch.data         <= '0;

		dir_table = '{
			mv(0, 0, 1, 0, 1, 0),                         // no movement from reset
			mv(100, 0, 1, 0, 0, 0),
			mv(150, 0, 0, 0, 1, 0),                       // laser off
			mv(150, 0, 1, 1, 1, 0),                       // pulse still running
			mv(300, 0, 1, 0, 0, 0),
			mv(300, 40, 1, 0, 0, 0),
			mv(32'sh7FFF_FFFF, 32'sh8000_0000, 1, 0, 1, 1), // both deltas saturate
			mv(32'sh8000_0000, 32'sh7FFF_FFFF, 1, 0, 1, 1),
			mv(32'sh8000_0000, 32'sh7FFF_FFFF, 1, 0, 1, 0),
			mv(32'sh8000_7FFF, 32'sh7FFF_FFFF, 1, 0, 1, 1), // delta right at the limit
			mv(32'sh8000_7FFF, 32'sh7FFF_7FFF, 1, 0, 0, 0), // one past the limit
			mv(-1, -1, 1, 0, 0, 0),
			mv(0, 0, 1, 0, 0, 0),
			wr(1'b0, ldpt_pkg::SPACING_RESET),            // pass-through
			mv(5000, 5000, 1, 0, 1, 0),
			mv(-5000, 7, 0, 1, 1, 0),
			wr(1'b1, 24'd0),                              // zero spacing
			mv(0, 0, 1, 0, 1, 0),
			mv(0, 1, 1, 0, 1, 1),
			wr(1'b1, 24'd1),
			mv(1, 1, 1, 0, 1, 1),
			wr(1'b1, 24'hFF_FFFF),
			mv(1, 1, 1, 0, 1, 0),
			mv(32768, 1, 1, 0, 0, 0),
			mv(-32767, -32767, 1, 0, 0, 0)
		};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_table[i]) begin
			if (dir_table[i].kind == ROW_WRITE) begin
				settle();
				write_regs(dir_table[i].ppi, dir_table[i].spacing);
			end else begin
				push_sample(dir_table[i].s, dir_table[i].known, dir_table[i].fire);
				maybe_pause();
			end
		end
		walk_x = -32767;
		walk_y = -32767;

		for (ph = 0; ph < 6; ph++) begin
			settle();
			mode    = 1'b1;
			big_pct = 10;
			case (ph)
				0: spacing = ldpt_pkg::SPACING_RESET;
				1: spacing = 24'd1;
				2: begin
					spacing = 24'hFF_FFFF;
					big_pct = 60;
				end
				3: begin
					mode    = 1'b0;
					spacing = ldpt_pkg::SPACING_W'($urandom_range(24'hFF_FFFF, 1));
				end
				4: spacing = ldpt_pkg::SPACING_W'($urandom_range(200000, 256));
				default: spacing = ldpt_pkg::SPACING_W'($urandom_range(2000000, 1000));
			endcase
			calm <= (ph == 4);
			write_regs(mode, spacing);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// hold the receiver while samples keep coming
				if (ph == 1 && n == 20)
					hold_asked <= hold_asked + 1;
				if (ph == 5 && n == 80)
					settle();
				push_sample(next_sample(), 1'b0, 1'b0);
				maybe_pause();
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fire_expect_q.size() != 0)
			note_fail($sformatf("%0d expected results never arrived", fire_expect_q.size()));
		if (err_count == 0)
			$display("laser_distance_pulse_trigger verification clean");
		else
			$display("laser_distance_pulse_trigger verification failed");
		$finish;
	end

endmodule
